/* src/flsm_pkg.sv */
`timescale 1ns / 1ps
// Shared constants, word types and helper functions of the load/store memory unit.
package flsm_pkg;

  localparam int ADDR_BITS = 17;
  localparam int MEM_BYTES = 1 << ADDR_BITS;
  localparam int LATENCY   = 3;
  localparam int WAIT_BITS = $clog2(LATENCY + 1);
  localparam int TAG_BITS  = 5;
  localparam int CNT_BITS  = 3;

  localparam logic [CNT_BITS-1:0] WORD_BYTES = CNT_BITS'(4);

  localparam logic [2:0] LD_SB = 3'd0;
  localparam logic [2:0] LD_SH = 3'd1;
  localparam logic [2:0] LD_W  = 3'd2;
  localparam logic [2:0] LD_UB = 3'd3;
  localparam logic [2:0] LD_UH = 3'd4;

  localparam logic [1:0] ST_B = 2'd0;
  localparam logic [1:0] ST_H = 2'd1;
  localparam logic [1:0] ST_W = 2'd2;

  typedef struct packed {
    logic                flush;
    logic                load_valid;
    logic [2:0]          load_kind;
    logic [31:0]         load_addr;
    logic [TAG_BITS-1:0] load_tag;
    logic                store_valid;
    logic [1:0]          store_kind;
    logic [31:0]         store_addr;
    logic [31:0]         store_value;
    logic [31:0]         fetch_addr;
  } in_t;

  typedef struct packed {
    logic                result_valid;
    logic [TAG_BITS-1:0] result_tag;
    logic [31:0]         result_data;
    logic                unit_busy;
    logic [31:0]         fetch_word;
  } out_t;

  typedef struct packed {
    logic                 en;
    logic                 we;
    logic [ADDR_BITS-1:0] addr;
    logic [7:0]           wdata;
  } mem_req_t;

  function automatic logic [CNT_BITS-1:0] ld_bytes(input logic [2:0] kind);
    logic [CNT_BITS-1:0] n;
    case (kind)
      LD_SB, LD_UB: n = CNT_BITS'(1);
      LD_SH, LD_UH: n = CNT_BITS'(2);
      default:      n = WORD_BYTES;
    endcase
    return n;
  endfunction

  function automatic logic [CNT_BITS-1:0] st_bytes(input logic [1:0] kind);
    logic [CNT_BITS-1:0] n;
    case (kind)
      ST_B:    n = CNT_BITS'(1);
      ST_H:    n = CNT_BITS'(2);
      default: n = WORD_BYTES;
    endcase
    return n;
  endfunction

endpackage

/* src/flsm_ram.sv */
`timescale 1ns / 1ps
// Single-port byte memory with registered read data.
module flsm_ram (
  input  logic               clk,
  input  flsm_pkg::mem_req_t req,
  output logic [7:0]         rd_data
);

  logic [7:0] mem [flsm_pkg::MEM_BYTES];
  logic [7:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (req.en) begin
      if (req.we) begin
        mem[req.addr] <= req.wdata;
      end else begin
        rd_data_r <= mem[req.addr];
      end
    end
  end

  assign rd_data = rd_data_r;

endmodule

/* src/fixed_latency_load_store_memory_unit.sv */
`timescale 1ns / 1ps
// Fixed-latency load/store memory unit: byte-serial sequencer over one byte RAM port.
// Each word: fetch at fetch_addr, decide, then an optional byte load and extension, an
// optional byte store, then output. One word in flight: in_stall is high from accept until
// the output word is taken, so a new word is accepted only once the last one is finished.
// Reset: synchronous, active low; then a clearing pass writes zero to every one of the
// 2^ADDR_BITS = 131072 bytes, one per cycle, with in_stall high throughout.
module fixed_latency_load_store_memory_unit (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  flsm_pkg::in_t  in_word,
  output logic           out_valid,
  input  logic           out_stall,
  output flsm_pkg::out_t out_word
);

  typedef enum logic [7:0] {
    S_CLEAR  = 8'b0000_0001,
    S_IDLE   = 8'b0000_0010,
    S_FETCH  = 8'b0000_0100,
    S_DECIDE = 8'b0000_1000,
    S_LOAD   = 8'b0001_0000,
    S_LEXT   = 8'b0010_0000,
    S_STORE  = 8'b0100_0000,
    S_OUT    = 8'b1000_0000
  } state_t;

  localparam int AB = flsm_pkg::ADDR_BITS;
  localparam int CB = flsm_pkg::CNT_BITS;
  localparam int WB = flsm_pkg::WAIT_BITS;
  localparam int TB = flsm_pkg::TAG_BITS;

  state_t                state_r, state_nxt;
  flsm_pkg::in_t         item_r, item_nxt;
  flsm_pkg::out_t        res_r, res_nxt;
  logic [CB-1:0]         cnt_r, cnt_nxt;
  logic [AB-1:0]         clr_r, clr_nxt;
  logic                  rd_pend_r, rd_pend_nxt;
  logic [31:0]           asm_r, asm_nxt;
  logic [31:0]           sdata_r, sdata_nxt;
  logic                  store_go_r, store_go_nxt;

  logic                  pend_r, pend_nxt;
  logic [WB-1:0]         wait_r, wait_nxt;
  logic                  hlv_r, hlv_nxt;
  logic [2:0]            hlk_r, hlk_nxt;
  logic [31:0]           hla_r, hla_nxt;
  logic [TB-1:0]         hlt_r, hlt_nxt;
  logic                  hsv_r, hsv_nxt;
  logic [1:0]            hsk_r, hsk_nxt;
  logic [31:0]           hsa_r, hsa_nxt;
  logic [31:0]           hsd_r, hsd_nxt;

  flsm_pkg::mem_req_t    mem_req;
  logic [7:0]            mem_rdata;
  logic [31:0]           base;
  logic [AB-1:0]         addr_sum;
  logic [CB-1:0]         ld_n;
  logic [CB-1:0]         st_n;
  logic                  latch;
  logic                  load_go;

  flsm_ram u_ram (
    .clk     (clk),
    .req     (mem_req),
    .rd_data (mem_rdata)
  );

  assign ld_n     = flsm_pkg::ld_bytes(hlk_r);
  assign st_n     = flsm_pkg::st_bytes(hsk_r);
  assign in_stall = (state_r != S_IDLE);
  assign out_valid = (state_r == S_OUT);
  assign out_word  = res_r;

  // shared byte address adder
  always_comb begin
    case (state_r)
      S_LOAD:  base = hla_r;
      S_STORE: base = hsa_r;
      default: base = item_r.fetch_addr;
    endcase
    addr_sum = base[AB-1:0] + AB'(cnt_r);
  end

  always_comb begin
    mem_req.en    = 1'b0;
    mem_req.we    = 1'b0;
    mem_req.addr  = addr_sum;
    mem_req.wdata = sdata_r[7:0];
    case (state_r)
      S_CLEAR: begin
        mem_req.en    = 1'b1;
        mem_req.we    = 1'b1;
        mem_req.addr  = clr_r;
        mem_req.wdata = 8'h00;
      end
      S_FETCH: begin
        mem_req.en = (cnt_r != flsm_pkg::WORD_BYTES);
      end
      S_LOAD: begin
        mem_req.en = (cnt_r != ld_n);
      end
      S_STORE: begin
        mem_req.en = 1'b1;
        mem_req.we = 1'b1;
      end
      default: begin
        mem_req.en = 1'b0;
      end
    endcase
  end

  assign rd_pend_nxt = mem_req.en & ~mem_req.we;
  assign asm_nxt     = rd_pend_r ? {mem_rdata, asm_r[31:8]} : asm_r;

  always_comb begin
    state_nxt    = state_r;
    item_nxt     = item_r;
    res_nxt      = res_r;
    cnt_nxt      = cnt_r;
    clr_nxt      = clr_r;
    sdata_nxt    = sdata_r;
    store_go_nxt = store_go_r;
    pend_nxt     = pend_r;
    wait_nxt     = wait_r;
    hlv_nxt      = hlv_r;
    hlk_nxt      = hlk_r;
    hla_nxt      = hla_r;
    hlt_nxt      = hlt_r;
    hsv_nxt      = hsv_r;
    hsk_nxt      = hsk_r;
    hsa_nxt      = hsa_r;
    hsd_nxt      = hsd_r;
    latch        = 1'b0;
    load_go      = 1'b0;

    case (state_r)
      S_CLEAR: begin
        clr_nxt = clr_r + AB'(1);
        if (clr_r == {AB{1'b1}}) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        cnt_nxt = '0;
        if (in_valid) begin
          item_nxt  = in_word;
          state_nxt = S_FETCH;
        end
      end
      S_FETCH: begin
        if (cnt_r == flsm_pkg::WORD_BYTES) begin
          cnt_nxt   = '0;
          state_nxt = S_DECIDE;
        end else begin
          cnt_nxt = cnt_r + CB'(1);
        end
      end
      S_DECIDE: begin
        res_nxt.result_valid = 1'b0;
        res_nxt.result_tag   = '0;
        res_nxt.result_data  = '0;
        res_nxt.fetch_word   = asm_r;
        store_go_nxt         = 1'b0;
        sdata_nxt            = hsd_r;
        cnt_nxt              = '0;
        latch = ~item_r.flush & ~pend_r & (item_r.load_valid | item_r.store_valid);
        if (item_r.flush) begin
          if (pend_r && hlv_r && !hsv_r) begin
            pend_nxt = 1'b0;
            wait_nxt = '0;
          end
        end else begin
          if (latch) begin
            hlv_nxt  = item_r.load_valid;
            hlk_nxt  = item_r.load_kind;
            hla_nxt  = item_r.load_addr;
            hlt_nxt  = item_r.load_tag;
            hsv_nxt  = item_r.store_valid;
            hsk_nxt  = item_r.store_kind;
            hsa_nxt  = item_r.store_addr;
            hsd_nxt  = item_r.store_value;
            pend_nxt = 1'b1;
          end
          if (pend_r || latch) begin
            if (wait_r != WB'(flsm_pkg::LATENCY)) begin
              wait_nxt = wait_r + WB'(1);
            end else begin
              // latched request performs here; held values are stable on this tick
              load_go      = hlv_r & (hlk_r <= flsm_pkg::LD_UH);
              store_go_nxt = hsv_r & (hsk_r <= flsm_pkg::ST_W);
              pend_nxt     = 1'b0;
              wait_nxt     = '0;
            end
          end
        end
        res_nxt.unit_busy = pend_nxt;
        if (load_go) begin
          state_nxt = S_LOAD;
        end else if (store_go_nxt) begin
          state_nxt = S_STORE;
        end else begin
          state_nxt = S_OUT;
        end
      end
      S_LOAD: begin
        if (cnt_r == ld_n) begin
          cnt_nxt   = '0;
          state_nxt = S_LEXT;
        end else begin
          cnt_nxt = cnt_r + CB'(1);
        end
      end
      S_LEXT: begin
        res_nxt.result_valid = 1'b1;
        res_nxt.result_tag   = hlt_r;
        case (hlk_r)
          flsm_pkg::LD_SB: res_nxt.result_data = {{24{asm_r[31]}}, asm_r[31:24]};
          flsm_pkg::LD_UB: res_nxt.result_data = {24'h000000, asm_r[31:24]};
          flsm_pkg::LD_SH: res_nxt.result_data = {{16{asm_r[31]}}, asm_r[31:16]};
          flsm_pkg::LD_UH: res_nxt.result_data = {16'h0000, asm_r[31:16]};
          default:         res_nxt.result_data = asm_r;
        endcase
        cnt_nxt   = '0;
        state_nxt = store_go_r ? S_STORE : S_OUT;
      end
      S_STORE: begin
        sdata_nxt = {8'h00, sdata_r[31:8]};
        cnt_nxt   = cnt_r + CB'(1);
        if (cnt_r == st_n - CB'(1)) begin
          cnt_nxt   = '0;
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_stall) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_CLEAR;
      clr_r      <= '0;
      cnt_r      <= '0;
      rd_pend_r  <= 1'b0;
      store_go_r <= 1'b0;
      pend_r     <= 1'b0;
      wait_r     <= '0;
      hlv_r      <= 1'b0;
      hsv_r      <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      clr_r      <= clr_nxt;
      cnt_r      <= cnt_nxt;
      rd_pend_r  <= rd_pend_nxt;
      store_go_r <= store_go_nxt;
      pend_r     <= pend_nxt;
      wait_r     <= wait_nxt;
      hlv_r      <= hlv_nxt;
      hsv_r      <= hsv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r  <= item_nxt;
    res_r   <= res_nxt;
    asm_r   <= asm_nxt;
    sdata_r <= sdata_nxt;
    hlk_r   <= hlk_nxt;
    hla_r   <= hla_nxt;
    hlt_r   <= hlt_nxt;
    hsk_r   <= hsk_nxt;
    hsa_r   <= hsa_nxt;
    hsd_r   <= hsd_nxt;
  end

endmodule
